/* hw/rtl/rsnp_pkg.sv */
`timescale 1ns / 1ps
// rsnp_pkg: shared types, widths and codes for the ray/sphere nearest pick block
// no dependencies
package rsnp_pkg;

	localparam int MAX_OBJECTS_DEF = 256;

	localparam int COORD_W   = 32;
	localparam int DIR_W     = 18;
	localparam int RAD_CFG_W = 31;
	localparam int IDX_OUT_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	localparam int V_W    = COORD_W + 1;   // o - c
	localparam int B_W    = 53;            // d.v, |b| < 2^51
	localparam int MB_W   = 52;            // |b|
	localparam int HALF_W = 26;            // split of |b| for squaring
	localparam int OPD_W  = 35;            // shared multiplier operand
	localparam int PRD_W  = 2 * OPD_W;
	localparam int ACC_W  = 106;           // delta in units of 2^-64
	localparam int SQ_RAD_W  = 104;
	localparam int SQ_ROOT_W = 52;
	localparam int SQ_REM_W  = SQ_ROOT_W + 2;
	localparam int SQ_CNT_W  = 6;
	localparam int T_W    = 55;            // -b - sqrt, units of 2^-32
	localparam int FRAC_W = 16;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd6;

	localparam logic signed [DIR_W-1:0]  DIR_Z_RST  = 18'sd65536;
	localparam logic [RAD_CFG_W-1:0]     RADIUS_RST = 31'd65536;

	// multiply sequence, one product issued per step
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_BX  = 4'd0;
	localparam logic [OP_W-1:0] OP_BY  = 4'd1;
	localparam logic [OP_W-1:0] OP_BZ  = 4'd2;
	localparam logic [OP_W-1:0] OP_RR  = 4'd3;
	localparam logic [OP_W-1:0] OP_VX2 = 4'd4;
	localparam logic [OP_W-1:0] OP_VY2 = 4'd5;
	localparam logic [OP_W-1:0] OP_VZ2 = 4'd6;
	localparam logic [OP_W-1:0] OP_BHH = 4'd7;
	localparam logic [OP_W-1:0] OP_BHL = 4'd8;
	localparam logic [OP_W-1:0] OP_BLL = 4'd9;
	localparam logic [OP_W-1:0] OP_END = 4'd10;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_CHECK,
		S_SQRT,
		S_DIST,
		S_UPD,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] origin_x;
		logic signed [COORD_W-1:0] origin_y;
		logic signed [COORD_W-1:0] origin_z;
		logic signed [DIR_W-1:0]   dir_x;
		logic signed [DIR_W-1:0]   dir_y;
		logic signed [DIR_W-1:0]   dir_z;
		logic [RAD_CFG_W-1:0]      radius;
	} ray_cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sqrt_stat_t;

endpackage

/* hw/rtl/rsnp_if.sv */
`timescale 1ns / 1ps
// rsnp_sphere_if and rsnp_pick_if: valid/ready channels of the pick block
// depends on rsnp_pkg
interface rsnp_sphere_if;
	import rsnp_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] centre_x;
	logic signed [COORD_W-1:0] centre_y;
	logic signed [COORD_W-1:0] centre_z;
	logic                      last_object;

	modport source (output valid, centre_x, centre_y, centre_z, last_object, input ready);
	modport sink   (input valid, centre_x, centre_y, centre_z, last_object, output ready);
endinterface

interface rsnp_pick_if;
	import rsnp_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      hit_found;
	logic [IDX_OUT_W-1:0]      hit_index;
	logic signed [COORD_W-1:0] hit_distance;

	modport source (output valid, hit_found, hit_index, hit_distance, input ready);
	modport sink   (input valid, hit_found, hit_index, hit_distance, output ready);
endinterface

/* hw/rtl/rsnp_cfg.sv */
`timescale 1ns / 1ps
// rsnp_cfg: ray origin, direction and radius registers behind the write port
// depends on rsnp_pkg
module rsnp_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rsnp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rsnp_pkg::CFG_DAT_W-1:0] cfg_wdata,
	output rsnp_pkg::ray_cfg_t             ray
);
	import rsnp_pkg::*;

	ray_cfg_t ray_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ray_q.origin_x <= '0;
			ray_q.origin_y <= '0;
			ray_q.origin_z <= '0;
			ray_q.dir_x    <= '0;
			ray_q.dir_y    <= '0;
			ray_q.dir_z    <= DIR_Z_RST;
			ray_q.radius   <= RADIUS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORIGIN_X: ray_q.origin_x <= $signed(cfg_wdata[COORD_W-1:0]);
				REG_ORIGIN_Y: ray_q.origin_y <= $signed(cfg_wdata[COORD_W-1:0]);
				REG_ORIGIN_Z: ray_q.origin_z <= $signed(cfg_wdata[COORD_W-1:0]);
				REG_DIR_X:    ray_q.dir_x    <= $signed(cfg_wdata[DIR_W-1:0]);
				REG_DIR_Y:    ray_q.dir_y    <= $signed(cfg_wdata[DIR_W-1:0]);
				REG_DIR_Z:    ray_q.dir_z    <= $signed(cfg_wdata[DIR_W-1:0]);
				REG_RADIUS:   ray_q.radius   <= cfg_wdata[RAD_CFG_W-1:0];
				default: begin
					// unmapped index, write ignored
				end
			endcase
		end
	end

	assign ray = ray_q;

endmodule

/* hw/rtl/rsnp_mul.sv */
`timescale 1ns / 1ps
// rsnp_mul: shared signed multiplier with a registered product
// depends on rsnp_pkg
module rsnp_mul (
	input  logic                                clk,
	input  logic signed [rsnp_pkg::OPD_W-1:0]   opa,
	input  logic signed [rsnp_pkg::OPD_W-1:0]   opb,
	output logic signed [rsnp_pkg::PRD_W-1:0]   prod_s1
);
	import rsnp_pkg::*;

	always_ff @(posedge clk) begin
		prod_s1 <= PRD_W'(opa) * PRD_W'(opb);
	end

endmodule

/* hw/rtl/rsnp_sqrt.sv */
`timescale 1ns / 1ps
// rsnp_sqrt: floor square root, one root bit per cycle (restoring, digit by digit)
// depends on rsnp_pkg
module rsnp_sqrt (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [rsnp_pkg::SQ_RAD_W-1:0]    radicand,
	output logic [rsnp_pkg::SQ_ROOT_W-1:0]   root,
	output rsnp_pkg::sqrt_stat_t             stat
);
	import rsnp_pkg::*;

	logic [SQ_RAD_W-1:0]  rad_q;
	logic [SQ_REM_W-1:0]  rem_q;
	logic [SQ_ROOT_W-1:0] root_q;
	logic [SQ_CNT_W-1:0]  cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [SQ_REM_W-1:0]  rem_sh;
	logic [SQ_REM_W-1:0]  trial;
	logic                 take;

	// bring down the next two radicand bits and try root*4+1
	assign rem_sh = {rem_q[SQ_REM_W-3:0], rad_q[SQ_RAD_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign take   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// one cycle pulse after the last root bit
			done_q <= !start && busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SQ_CNT_W'(SQ_ROOT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SQ_RAD_W-3:0], 2'b00};
			rem_q  <= take ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[SQ_ROOT_W-2:0], take};
		end
	end

	assign root      = root_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* hw/rtl/ray_sphere_nearest_pick.sv */
`timescale 1ns / 1ps
// ray_sphere_nearest_pick: one sphere word in, nearest hit word out on the last sphere.
// each sphere under the object limit goes through 10 products on the shared multiplier
// and, on a hit, the bit-serial square root; the last sphere also visits the emit state.
// throughput: one sphere at a time, input ready only while idle; a finished result waits
// in its output register while the next spheres are taken.
// reset: async active low, clears sequencer, running pick state and config to defaults.
module ray_sphere_nearest_pick #(
	parameter int MAX_OBJECTS = rsnp_pkg::MAX_OBJECTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rsnp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rsnp_pkg::CFG_DAT_W-1:0] cfg_wdata,
	rsnp_sphere_if.sink                    sphere,
	rsnp_pick_if.source                    pick
);
	import rsnp_pkg::*;

	// stream position needs to reach MAX_OBJECTS itself (it saturates there)
	localparam int IW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
	localparam int CW = $clog2(MAX_OBJECTS + 1);

	ray_cfg_t ray;

	// sequencer
	state_t state_q, state_d;
	logic [OP_W-1:0] op_q;
	logic [OP_W-1:0] tag_s1;
	logic            tag_vld_s1;

	// per sphere working registers
	logic signed [V_W-1:0]   vx_q, vy_q, vz_q;
	logic signed [B_W-1:0]   b_q;
	logic [MB_W-1:0]         mb_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                    last_q;
	logic                    hit_q;
	logic signed [COORD_W-1:0] dist_q;

	// running pick state
	logic [CW-1:0]             item_cnt_q;
	logic [IW-1:0]             best_idx_q;
	logic signed [COORD_W-1:0] best_dist_q;
	logic                      have_hit_q;

	// result register
	logic                      pick_vld_q;
	logic                      pick_hit_q;
	logic [IDX_OUT_W-1:0]      pick_idx_q;
	logic signed [COORD_W-1:0] pick_dist_q;

	// control strobes
	logic take;
	logic in_range;
	logic emit_go;
	logic sq_start;

	// shared units
	logic signed [OPD_W-1:0] opa, opb;
	logic signed [PRD_W-1:0] prod_s1;
	logic [SQ_ROOT_W-1:0]    sq_root;
	sqrt_stat_t              sq_stat;

	// datapath helpers
	logic signed [ACC_W-1:0] prod_ext;
	logic signed [ACC_W-1:0] addend;
	logic                    acc_sub;
	logic signed [T_W-1:0]   t_full;
	logic signed [T_W-FRAC_W-1:0] t_q16;
	logic signed [COORD_W-1:0]    t_sat;
	logic [IW+IDX_OUT_W-1:0] idx_ext;

	rsnp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.ray       (ray)
	);

	rsnp_mul u_mul (
		.clk     (clk),
		.opa     (opa),
		.opb     (opb),
		.prod_s1 (prod_s1)
	);

	rsnp_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (acc_q[SQ_RAD_W-1:0]),
		.root     (sq_root),
		.stat     (sq_stat)
	);

	assign take     = sphere.valid && (state_q == S_IDLE);
	assign in_range = (item_cnt_q < CW'(MAX_OBJECTS));
	assign emit_go  = (state_q == S_EMIT) && (!pick_vld_q || pick.ready);
	assign sphere.ready = (state_q == S_IDLE);

	// ---------------------------------------------------------------------------
	// sequencer: accept, 10 products, sign test of delta, sqrt, distance, emit after the last update
	// ---------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		sq_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					// spheres past the object limit are counted out but still close a pick
					if (in_range) begin
						state_d = S_MUL;
					end else if (sphere.last_object) begin
						state_d = S_EMIT;
					end
				end
			end
			S_MUL: begin
				// last product lands in the accumulator on this edge
				if (op_q == OP_END) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				// delta < 0 is a miss, no root needed
				if (acc_q[ACC_W-1]) begin
					state_d = S_UPD;
				end else begin
					sq_start = 1'b1;
					state_d  = S_SQRT;
				end
			end
			S_SQRT: begin
				if (sq_stat.done) begin
					state_d = S_DIST;
				end
			end
			S_DIST: begin
				state_d = S_UPD;
			end
			S_UPD: begin
				state_d = last_q ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				if (emit_go) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------------------
	// multiplier operand select
	// b = d.v, then r^2, |v|^2 and b^2 from the two halves of |b|
	// ---------------------------------------------------------------------------
	always_comb begin
		opa = '0;
		opb = '0;
		case (op_q)
			OP_BX: begin
				opa = OPD_W'(ray.dir_x);
				opb = OPD_W'(vx_q);
			end
			OP_BY: begin
				opa = OPD_W'(ray.dir_y);
				opb = OPD_W'(vy_q);
			end
			OP_BZ: begin
				opa = OPD_W'(ray.dir_z);
				opb = OPD_W'(vz_q);
			end
			OP_RR: begin
				opa = $signed({{(OPD_W-RAD_CFG_W){1'b0}}, ray.radius});
				opb = $signed({{(OPD_W-RAD_CFG_W){1'b0}}, ray.radius});
			end
			OP_VX2: begin
				opa = OPD_W'(vx_q);
				opb = OPD_W'(vx_q);
			end
			OP_VY2: begin
				opa = OPD_W'(vy_q);
				opb = OPD_W'(vy_q);
			end
			OP_VZ2: begin
				opa = OPD_W'(vz_q);
				opb = OPD_W'(vz_q);
			end
			OP_BHH: begin
				opa = $signed({{(OPD_W-HALF_W){1'b0}}, mb_q[MB_W-1:HALF_W]});
				opb = $signed({{(OPD_W-HALF_W){1'b0}}, mb_q[MB_W-1:HALF_W]});
			end
			OP_BHL: begin
				opa = $signed({{(OPD_W-HALF_W){1'b0}}, mb_q[MB_W-1:HALF_W]});
				opb = $signed({{(OPD_W-HALF_W){1'b0}}, mb_q[HALF_W-1:0]});
			end
			OP_BLL: begin
				opa = $signed({{(OPD_W-HALF_W){1'b0}}, mb_q[HALF_W-1:0]});
				opb = $signed({{(OPD_W-HALF_W){1'b0}}, mb_q[HALF_W-1:0]});
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	// delta = b^2 + r^2*2^32 - |v|^2*2^32, all in units of 2^-64
	assign prod_ext = ACC_W'(prod_s1);

	always_comb begin
		addend  = '0;
		acc_sub = 1'b0;
		case (tag_s1)
			OP_RR:  addend = prod_ext <<< 32;
			OP_VX2: begin
				addend  = prod_ext <<< 32;
				acc_sub = 1'b1;
			end
			OP_VY2: begin
				addend  = prod_ext <<< 32;
				acc_sub = 1'b1;
			end
			OP_VZ2: begin
				addend  = prod_ext <<< 32;
				acc_sub = 1'b1;
			end
			OP_BHH: addend = prod_ext <<< (2 * HALF_W);
			OP_BHL: addend = prod_ext <<< (HALF_W + 1);
			OP_BLL: addend = prod_ext;
			default: begin
				addend  = '0;
				acc_sub = 1'b0;
			end
		endcase
	end

	// t = -b - sqrt(delta), floor to q16.16 by dropping 16 bits, then saturate
	assign t_full = -T_W'(b_q) - $signed({{(T_W-SQ_ROOT_W){1'b0}}, sq_root});
	assign t_q16  = t_full[T_W-1:FRAC_W];
	assign t_sat  = (t_q16[T_W-FRAC_W-1:COORD_W-1] == '0 || t_q16[T_W-FRAC_W-1:COORD_W-1] == '1)
		? t_q16[COORD_W-1:0]
		: (t_q16[T_W-FRAC_W-1] ? $signed({1'b1, {(COORD_W-1){1'b0}}})
			: $signed({1'b0, {(COORD_W-1){1'b1}}}));

	// ---------------------------------------------------------------------------
	// control registers
	// ---------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= '0;
			tag_s1      <= '0;
			tag_vld_s1  <= 1'b0;
			item_cnt_q  <= '0;
			best_idx_q  <= '0;
			best_dist_q <= '0;
			have_hit_q  <= 1'b0;
			pick_vld_q  <= 1'b0;
		end else begin
			// a product tag is registered alongside its product
			tag_vld_s1 <= (state_q == S_MUL) && (op_q != OP_END);
			if (take) begin
				op_q <= OP_BX;
			end else if (state_q == S_MUL && op_q != OP_END) begin
				op_q   <= op_q + 1'b1;
				tag_s1 <= op_q;
			end

			// keep the nearest hit, the earlier sphere wins a tie
			if (state_q == S_UPD) begin
				item_cnt_q <= item_cnt_q + 1'b1;
				if (hit_q && (!have_hit_q || dist_q < best_dist_q)) begin
					have_hit_q  <= 1'b1;
					best_idx_q  <= item_cnt_q[IW-1:0];
					best_dist_q <= dist_q;
				end
			end

			// a new word may load in the cycle the old one leaves
			if (emit_go) begin
				pick_vld_q <= 1'b1;
			end else if (pick_vld_q && pick.ready) begin
				pick_vld_q <= 1'b0;
			end
			if (emit_go) begin
				item_cnt_q  <= '0;
				best_idx_q  <= '0;
				best_dist_q <= '0;
				have_hit_q  <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------------
	// payload registers
	// ---------------------------------------------------------------------------
	assign idx_ext = {{IDX_OUT_W{1'b0}}, best_idx_q};

	always_ff @(posedge clk) begin
		if (take) begin
			vx_q   <= V_W'(ray.origin_x) - V_W'(sphere.centre_x);
			vy_q   <= V_W'(ray.origin_y) - V_W'(sphere.centre_y);
			vz_q   <= V_W'(ray.origin_z) - V_W'(sphere.centre_z);
			last_q <= sphere.last_object;
			b_q    <= '0;
			acc_q  <= '0;
			hit_q  <= 1'b0;
		end else begin
			if (tag_vld_s1) begin
				if (tag_s1 == OP_BX || tag_s1 == OP_BY || tag_s1 == OP_BZ) begin
					b_q <= b_q + prod_s1[B_W-1:0];
				end else begin
					acc_q <= acc_sub ? (acc_q - addend) : (acc_q + addend);
				end
			end
			if (state_q == S_DIST) begin
				dist_q <= t_sat;
				hit_q  <= 1'b1;
			end
		end
		// |b|, ready long before the squaring steps use it
		mb_q <= b_q[B_W-1] ? MB_W'(-b_q) : MB_W'(b_q);

		if (emit_go) begin
			pick_hit_q  <= have_hit_q;
			pick_idx_q  <= have_hit_q ? idx_ext[IDX_OUT_W-1:0] : '0;
			pick_dist_q <= have_hit_q ? best_dist_q : '0;
		end
	end

	assign pick.valid        = pick_vld_q;
	assign pick.hit_found    = pick_hit_q;
	assign pick.hit_index    = pick_idx_q;
	assign pick.hit_distance = pick_dist_q;

	// ---------------------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------------------
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		item_cnt_q <= CW'(MAX_OBJECTS))
		else $error("stream position ran past the object limit");

	a_sq_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sq_start |-> !sq_stat.busy)
		else $error("square root started while busy");

	a_sq_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		sq_stat.done |-> (state_q == S_SQRT))
		else $error("square root finished outside its wait state");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> (item_cnt_q == '0 && !have_hit_q && pick_vld_q))
		else $error("pick state not cleared after result load");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(pick_vld_q && !pick_hit_q) |-> (pick_idx_q == '0 && pick_dist_q == '0))
		else $error("empty pick carries index or distance");

endmodule
